// ----- src/assert_macros.svh -----
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked also during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rgbf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rgbf_pkg;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_FADE    = 2'd1,
    OP_BREATHE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_GAMMA  = 2'd0,
    REG_INVERT = 2'd1,
    REG_STEPS  = 2'd2
  } reg_idx_t;

  typedef logic [15:0] q15_t;

  typedef struct packed {
    logic [2:0][7:0] from_c;
    logic [2:0][7:0] to_c;
  } colour_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [14:0] quo;
  } div_state_t;

  localparam q15_t Q15_UNIT   = 16'h8000;
  localparam int   DIV_STAGES = 5;
  localparam int   DIV_BITS   = 3;
  localparam int   NSTG       = 14;
  localparam int   ST_DIV_END = DIV_STAGES;

  function automatic q15_t qmul(input q15_t a, input q15_t b);
    logic [30:0] p;
    begin
      p = 31'(32'(a) * 32'(b)) + 31'd16384;
      return p[30:15];
    end
  endfunction

  // one restoring division bit; rem stays below d
  function automatic div_state_t div_step(input div_state_t st, input logic [15:0] d);
    logic [16:0] r2;
    div_state_t  o;
    begin
      r2 = {st.rem, 1'b0};
      if (r2 >= {1'b0, d}) begin
        o.rem = 16'(r2 - {1'b0, d});
        o.quo = {st.quo[13:0], 1'b1};
      end else begin
        o.rem = r2[15:0];
        o.quo = {st.quo[13:0], 1'b0};
      end
      return o;
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/rgb_eased_fade_duty_generator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// RGB fade duty generator: one word in, one word of three 8-bit PWM duties out.
// A new word is taken every clock unless the output stalls; each word goes through
// one set-up stage, a five-stage divider at three quotient bits per stage, four
// multiply stages of the quintic easing curve, one clamp stage, one interpolation
// multiply stage and two gamma stages. A stalled output holds the whole pipeline.
// Registers are to be written through the APB port only while no word is in
// flight; the block does not enforce it. steps_r resets to 1, the rest to 0.

module rgb_eased_fade_duty_generator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // op[1:0], step_index[17:2], from_red, from_green, from_blue, to_red, to_green,
  // to_blue (8 bits each, from bit 18 up), zero pad [71:66]
  input  wire logic [71:0] in_tdata,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // duty_red[7:0], duty_green[15:8], duty_blue[23:16]
  output      logic [23:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);
  import rgbf_pkg::*;

  logic        gamma_r;
  logic        invert_r;
  logic [15:0] steps_r;
  logic        en;

  logic [NSTG-1:0] vld_r;

  // set-up stage
  op_t         op;
  logic [15:0] in_step;
  logic [15:0] n_fade, n_br, nm1, k_fade, k_br;
  logic [16:0] m_br;
  logic [15:0] m_nxt;
  logic [15:0] dv_nxt;
  logic        sat_nxt;
  colour_t     col_nxt;

  logic [15:0] rem_r [0:ST_DIV_END];
  logic [14:0] quo_r [0:ST_DIV_END];
  logic [15:0] dv_r  [0:ST_DIV_END];
  logic        sat_r [0:ST_DIV_END];
  colour_t     col_r [0:11];

  div_state_t  div_nxt [0:DIV_STAGES-1];

  q15_t t_nxt;
  q15_t st6_t_r, st6_t2_r;
  q15_t st7_t_r, st7_t3_r;
  q15_t st8_t_r, st8_t3_r, st8_t4_r;
  q15_t st9_t3_r, st9_t4_r, st9_t5_r;
  logic signed [21:0] s_full;
  q15_t s_nxt, st10_s_r;

  logic signed [25:0] prod_nxt [3];
  logic signed [25:0] st11_prod_r [3];
  logic        [7:0]  v_nxt [3];
  logic        [15:0] vsq_nxt [3];
  logic        [7:0]  st12_v_r [3];
  logic        [15:0] st12_vsq_r [3];
  logic        [7:0]  duty_nxt [3];
  logic        [7:0]  st13_duty_r [3];

  // configuration
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r  <= 1'b0;
      invert_r <= 1'b0;
      steps_r  <= 16'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_GAMMA:  gamma_r  <= cfg_pwdata[0];
        REG_INVERT: invert_r <= cfg_pwdata[0];
        REG_STEPS:  steps_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_GAMMA:  cfg_prdata = {31'd0, gamma_r};
      REG_INVERT: cfg_prdata = {31'd0, invert_r};
      REG_STEPS:  cfg_prdata = {16'd0, steps_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // handshake
  assign en         = !vld_r[NSTG-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {st13_duty_r[2], st13_duty_r[1], st13_duty_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // set-up: clamp step, pick numerator and divisor, catch full scale
  always_comb begin
    op      = op_t'(in_tdata[1:0]);
    in_step = in_tdata[17:2];
    col_nxt.from_c = {in_tdata[41:34], in_tdata[33:26], in_tdata[25:18]};
    col_nxt.to_c   = {in_tdata[65:58], in_tdata[57:50], in_tdata[49:42]};
    n_fade  = (steps_r == 16'd0) ? 16'd1 : steps_r;
    n_br    = (steps_r < 16'd2) ? 16'd2 : steps_r;
    nm1     = n_br - 16'd1;
    k_fade  = (in_step > n_fade) ? n_fade : in_step;
    k_br    = (in_step > nm1) ? nm1 : in_step;
    m_br    = (k_br <= (n_br >> 1)) ? {k_br, 1'b0} : {16'(nm1 - k_br), 1'b0};
    case (op)
      OP_FADE: begin
        m_nxt   = k_fade;
        dv_nxt  = n_fade;
        sat_nxt = ({1'b0, k_fade} >= {1'b0, n_fade});
      end
      OP_BREATHE: begin
        m_nxt   = m_br[15:0];
        dv_nxt  = nm1;
        sat_nxt = (m_br >= {1'b0, nm1});
        col_nxt.from_c = '0;
      end
      default: begin
        m_nxt   = 16'd0;
        dv_nxt  = 16'd1;
        sat_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= m_nxt;
      quo_r[0] <= '0;
      dv_r[0]  <= dv_nxt;
      sat_r[0] <= sat_nxt;
      col_r[0] <= col_nxt;
      for (int i = 1; i < 12; i++) col_r[i] <= col_r[i-1];
    end
  end

  // divider: t = 32768 * m / d, three bits per stage
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    always_comb begin
      div_nxt[j].rem = rem_r[j];
      div_nxt[j].quo = quo_r[j];
      for (int b = 0; b < DIV_BITS; b++) div_nxt[j] = div_step(div_nxt[j], dv_r[j]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= div_nxt[j].rem;
        quo_r[j+1] <= div_nxt[j].quo;
        dv_r[j+1]  <= dv_r[j];
        sat_r[j+1] <= sat_r[j];
      end
    end
  end

  // easing: 6t^5 - 15t^4 + 10t^3
  assign t_nxt = sat_r[ST_DIV_END] ? Q15_UNIT : {1'b0, quo_r[ST_DIV_END]};

  always_comb begin
    s_full = $signed({6'd0, st9_t5_r}) * 22'sd6 - $signed({6'd0, st9_t4_r}) * 22'sd15
           + $signed({6'd0, st9_t3_r}) * 22'sd10;
    if (s_full < 22'sd0) begin
      s_nxt = 16'd0;
    end else if (s_full > $signed({6'd0, Q15_UNIT})) begin
      s_nxt = Q15_UNIT;
    end else begin
      s_nxt = s_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st6_t_r  <= t_nxt;
      st6_t2_r <= qmul(t_nxt, t_nxt);
      st7_t_r  <= st6_t_r;
      st7_t3_r <= qmul(st6_t2_r, st6_t_r);
      st8_t_r  <= st7_t_r;
      st8_t3_r <= st7_t3_r;
      st8_t4_r <= qmul(st7_t3_r, st7_t_r);
      st9_t3_r <= st8_t3_r;
      st9_t4_r <= st8_t4_r;
      st9_t5_r <= qmul(st8_t4_r, st8_t_r);
      st10_s_r <= s_nxt;
    end
  end

  // interpolation and gamma, one lane per colour
  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic signed [8:0]  diff;
    logic signed [25:0] sh;
    logic        [8:0]  gm;
    logic        [25:0] y;
    logic        [7:0]  g, dsel;

    always_comb begin
      diff        = $signed({1'b0, col_r[10].to_c[c]}) - $signed({1'b0, col_r[10].from_c[c]});
      prod_nxt[c] = 26'(diff) * 26'($signed({1'b0, st10_s_r}));
      sh          = st11_prod_r[c] >>> 15;
      v_nxt[c]    = 8'({3'd0, col_r[11].from_c[c]} + sh[10:0]);
      vsq_nxt[c]  = 16'(v_nxt[c]) * 16'(v_nxt[c]);
      gm          = {1'b0, st12_v_r[c]} + 9'd255;
      y           = 26'(st12_vsq_r[c]) * 26'(gm) + 26'd32768;
      g           = (y[25:16] > 10'd255) ? 8'd255 : y[23:16];
      dsel        = gamma_r ? g : st12_v_r[c];
      duty_nxt[c] = invert_r ? (8'd255 - dsel) : dsel;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st11_prod_r[c] <= prod_nxt[c];
        st12_v_r[c]    <= v_nxt[c];
        st12_vsq_r[c]  <= vsq_nxt[c];
        st13_duty_r[c] <= duty_nxt[c];
      end
    end
  end

  `ASSERT_CLKD(a_div_rem, vld_r[ST_DIV_END] && !sat_r[ST_DIV_END] |-> rem_r[ST_DIV_END] < dv_r[ST_DIV_END], "divider remainder not below divisor")
  `ASSERT_CLKD(a_div_nonzero, vld_r[0] |-> dv_r[0] != 16'd0, "zero divisor entered divider")
  `ASSERT_CLKD(a_t_range, vld_r[6] |-> st6_t_r <= Q15_UNIT && st6_t2_r <= Q15_UNIT, "easing input above unit")
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result shown straight after reset")

endmodule

`default_nettype wire
